@@ hw/rtl/rpfc_pkg.sv @@
// ----------------------------------------------------------------------------
// rpfc_pkg
// Types, format codes and constants shared by the pixel format converter.
// ----------------------------------------------------------------------------
package rpfc_pkg;

    localparam int CHAN_W      = 8;
    localparam int DATA_W      = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int BIT_POS_W   = 3;

    typedef enum logic [1:0] {
        FMT_MONO   = 2'd0,
        FMT_RGB332 = 2'd1,
        FMT_RGB565 = 2'd2,
        FMT_BGRA   = 2'd3
    } t_fmt;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OUTPUT_FORMAT   = 2'd0,
        REG_ALPHA_THRESHOLD = 2'd1
    } t_reg_idx;

    localparam logic [CHAN_W-1:0] THRESH_RESET = 8'h80;
    localparam logic [7:0]        KEY_RGB332   = 8'hC0;
    localparam logic [15:0]       KEY_RGB565   = 16'hE000;

    typedef struct packed {
        logic [CHAN_W-1:0] alpha;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } t_pixel;

    typedef struct packed {
        logic                 has_result;
        logic [DATA_W-1:0]    data;
        logic [CHAN_W-1:0]    mono_accum;
        logic [BIT_POS_W-1:0] mono_bit_pos;
    } t_conv_res;

endpackage

@@ hw/rtl/rpfc_convert.sv @@
// ----------------------------------------------------------------------------
// rpfc_convert
// Per-pixel conversion: mono bit packing, RGB332, RGB565 and BGRA packing.
// ----------------------------------------------------------------------------
module rpfc_convert (
    input  rpfc_pkg::t_pixel                      i_pixel,
    input  logic                                  i_row_end,
    input  rpfc_pkg::t_fmt                        i_format,
    input  logic [rpfc_pkg::CHAN_W-1:0]           i_threshold,
    input  logic [rpfc_pkg::CHAN_W-1:0]           i_mono_accum,
    input  logic [rpfc_pkg::BIT_POS_W-1:0]        i_mono_bit_pos,
    output rpfc_pkg::t_conv_res                   o_res
);
    import rpfc_pkg::*;

    logic              keyed;
    logic              black;
    logic [CHAN_W-1:0] accum_set;
    logic [7:0]        rgb332;
    logic [15:0]       rgb565;

    always_comb begin
        keyed  = i_pixel.alpha < i_threshold;
        black  = (i_pixel.red == '0) && (i_pixel.green == '0) && (i_pixel.blue == '0);
        // The first pixel of a byte lands in the most significant bit.
        accum_set = i_mono_accum | ({{(CHAN_W-1){1'b0}}, black} << (3'd7 - i_mono_bit_pos));
        rgb332 = {i_pixel.red[7:5], i_pixel.green[7:5], i_pixel.blue[7:6]};
        rgb565 = {i_pixel.red[7:3], i_pixel.green[7:2], i_pixel.blue[7:3]};

        o_res.has_result   = 1'b1;
        o_res.data         = '0;
        o_res.mono_accum   = i_mono_accum;
        o_res.mono_bit_pos = i_mono_bit_pos;

        case (i_format)
            FMT_MONO: begin
                if (i_mono_bit_pos == 3'd7 || i_row_end) begin
                    o_res.data         = {24'd0, accum_set};
                    o_res.mono_accum   = '0;
                    o_res.mono_bit_pos = '0;
                end else begin
                    o_res.has_result   = 1'b0;
                    o_res.mono_accum   = accum_set;
                    o_res.mono_bit_pos = i_mono_bit_pos + 3'd1;
                end
            end
            FMT_RGB332: o_res.data = {24'd0, keyed ? KEY_RGB332 : rgb332};
            FMT_RGB565: o_res.data = {16'd0, keyed ? KEY_RGB565 : rgb565};
            FMT_BGRA:   o_res.data = {i_pixel.alpha, i_pixel.red, i_pixel.green,
                                      i_pixel.blue};
            default:    o_res.data = '0;
        endcase
    end

endmodule

@@ hw/rtl/rgba_pixel_format_converter.sv @@
// ----------------------------------------------------------------------------
// rgba_pixel_format_converter
// Converts an RGBA8888 pixel stream to mono 1bpp, RGB332, RGB565 or BGRA32.
// ----------------------------------------------------------------------------
// An accepted pixel loads the input register; its result loads the result
// register once that register is free. Throughput: one pixel per cycle
// unless the output stalls; mono mode gives one result per eight pixels or
// per row end. Reset (synchronous, active low) selects RGB565, threshold
// 128, and clears the mono byte state and both pipeline valids.
module rgba_pixel_format_converter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // red [7:0], green [15:8], blue [23:16], alpha [31:24]
    input  logic [rpfc_pkg::DATA_W-1:0]         s_axis_tdata,
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // pixel_data [31:0]
    output logic [rpfc_pkg::DATA_W-1:0]         m_axis_tdata,
    output logic                                m_axis_tlast,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rpfc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rpfc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import rpfc_pkg::*;

    t_fmt                 r_format;
    logic [CHAN_W-1:0]    r_threshold;
    logic [CHAN_W-1:0]    r_mono_accum;
    logic [BIT_POS_W-1:0] r_mono_bit_pos;

    logic                 r_in_valid;
    t_pixel               r_in_pixel;
    logic                 r_in_last;

    logic                 r_out_valid;
    logic [DATA_W-1:0]    r_out_data;
    logic                 r_out_last;

    t_conv_res            conv;
    logic                 out_free;
    logic                 in_adv;
    logic                 in_take;
    logic                 cfg_wr;

    rpfc_convert u_convert (
        .i_pixel        (r_in_pixel),
        .i_row_end      (r_in_last),
        .i_format       (r_format),
        .i_threshold    (r_threshold),
        .i_mono_accum   (r_mono_accum),
        .i_mono_bit_pos (r_mono_bit_pos),
        .o_res          (conv)
    );

    assign out_free      = !r_out_valid || m_axis_tready;
    // A mono pixel that completes no byte leaves the input stage without
    // needing room in the result register.
    assign in_adv        = r_in_valid && (out_free || !conv.has_result);
    assign s_axis_tready = !r_in_valid || in_adv;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign cfg_wr        = i_cfg_valid && o_cfg_ready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format       <= FMT_RGB565;
            r_threshold    <= THRESH_RESET;
            r_mono_accum   <= '0;
            r_mono_bit_pos <= '0;
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (cfg_wr && i_cfg_index == REG_OUTPUT_FORMAT) begin
                r_format       <= t_fmt'(i_cfg_data[1:0]);
                r_mono_accum   <= '0;
                r_mono_bit_pos <= '0;
            end else if (in_adv) begin
                r_mono_accum   <= conv.mono_accum;
                r_mono_bit_pos <= conv.mono_bit_pos;
            end
            if (cfg_wr && i_cfg_index == REG_ALPHA_THRESHOLD) begin
                r_threshold <= i_cfg_data;
            end

            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (in_adv) begin
                r_in_valid <= 1'b0;
            end

            if (in_adv && conv.has_result) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_pixel <= t_pixel'(s_axis_tdata);
            r_in_last  <= s_axis_tlast;
        end
        if (in_adv && conv.has_result) begin
            r_out_data <= conv.data;
            r_out_last <= r_in_last;
        end
    end

endmodule

@@ sim/rgba_pixel_format_converter_tb.sv @@
// ----------------------------------------------------------------------------
// rgba_pixel_format_converter_tb
// Streams RGBA8888 pixels through the converter in every output format and
// checks each converted word and its row flag against a local predictor.
// Formats and alpha thresholds change between phases while the block is
// idle, and both stream sides idle at random rates that vary by phase.
// ----------------------------------------------------------------------------
module rgba_pixel_format_converter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rpfc_pkg::*;

    localparam int DRAIN_CYCLES = 8;
    localparam int PHASES       = 16;
    localparam int PHASE_PIXELS = 106;

    // Register indexes past the end of the map; writes to them are dropped.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    typedef struct {
        t_pixel px;
        logic   row_end;
    } t_px_item;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              last;
    } t_out_word;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // red [7:0], green [15:8], blue [23:16], alpha [31:24]
    logic [DATA_W-1:0]     s_axis_tdata = '0;
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // pixel_data [31:0]
    logic [DATA_W-1:0]     m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // Predictor state: a copy of the registers and the mono byte under way.
    t_fmt                  cfg_fmt = FMT_RGB565;
    logic [CHAN_W-1:0]     cfg_thr = THRESH_RESET;
    logic [7:0]            mono_bits = '0;
    logic [2:0]            mono_pos = '0;

    t_px_item              pixel_q[$];
    t_px_item              cur_item;
    t_out_word             awaited_words[$];
    int                    queued_cnt = 0;
    int                    accepted_cnt = 0;
    int                    err_cnt = 0;
    int                    src_idle_pct = 0;
    int                    sink_stall_pct = 0;

    rgba_pixel_format_converter DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Converts one pixel under the current settings. Returns 1 when the pixel
    // completes an output word, which is then returned in word.
    function automatic bit convert_pixel(input t_pixel px, input logic row_end,
                                         output t_out_word word);
        word = '0;
        word.last = row_end;
        if (cfg_fmt == FMT_MONO) begin
            if (px.red == 8'd0 && px.green == 8'd0 && px.blue == 8'd0) begin
                mono_bits[3'd7 - mono_pos] = 1'b1;
            end
            if (mono_pos == 3'd7 || row_end) begin
                word.data = {24'd0, mono_bits};
                mono_bits = '0;
                mono_pos = '0;
                return 1'b1;
            end
            mono_pos = mono_pos + 3'd1;
            return 1'b0;
        end
        case (cfg_fmt)
            FMT_RGB332: begin
                if (px.alpha < cfg_thr) begin
                    word.data = {24'd0, KEY_RGB332};
                end else begin
                    word.data = {24'd0, px.red[7:5], px.green[7:5], px.blue[7:6]};
                end
            end
            FMT_RGB565: begin
                if (px.alpha < cfg_thr) begin
                    word.data = {16'd0, KEY_RGB565};
                end else begin
                    word.data = {16'd0, px.red[7:3], px.green[7:2], px.blue[7:3]};
                end
            end
            default: begin
                word.data = {px.alpha, px.red, px.green, px.blue};
            end
        endcase
        return 1'b1;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        err_cnt++;
        if (err_cnt <= 10) begin
            $display("mismatch on %s: expected 0x%08h, got 0x%08h", what, want, got);
        end
    endtask

    // Pixel driver.
    always @(posedge i_clk) begin
        t_out_word word;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                accepted_cnt++;
                if (convert_pixel(cur_item.px, cur_item.row_end, word)) begin
                    awaited_words.push_back(word);
                end
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pixel_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                    cur_item = pixel_q.pop_front();
                    s_axis_tdata  <= cur_item.px;
                    s_axis_tlast  <= cur_item.row_end;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (awaited_words.size() == 0) begin
                    flag_mismatch("result with nothing pending", '0, m_axis_tdata);
                end else begin
                    want = awaited_words.pop_front();
                    if (m_axis_tdata !== want.data) begin
                        flag_mismatch("pixel_data", want.data, m_axis_tdata);
                    end
                    if (m_axis_tlast !== want.last) begin
                        flag_mismatch("row_last", 32'(want.last), 32'(m_axis_tlast));
                    end
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == REG_OUTPUT_FORMAT) begin
            cfg_fmt = t_fmt'(value[1:0]);
            mono_bits = '0;
            mono_pos = '0;
        end else if (idx == REG_ALPHA_THRESHOLD) begin
            cfg_thr = value;
        end
    endtask

    // Format writes carry random upper bits, which the block must ignore.
    task automatic write_format(input t_fmt fmt);
        write_reg(REG_OUTPUT_FORMAT, {6'($urandom_range(0, 63)), fmt});
    endtask

    task automatic push_pixel(input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b, input logic [7:0] a,
                              input logic row_end);
        t_px_item item;
        item.px.red   = r;
        item.px.green = g;
        item.px.blue  = b;
        item.px.alpha = a;
        item.row_end  = row_end;
        pixel_q.push_back(item);
        queued_cnt++;
    endtask

    // Waits until every pixel is taken and every word has come back. A mono
    // byte can still be in the pipeline without a word, hence the extra pause.
    task automatic settle();
        while (accepted_cnt != queued_cnt || awaited_words.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_pixel rand_pixel();
        t_pixel p;
        p.red   = 8'($urandom_range(0, 255));
        p.green = 8'($urandom_range(0, 255));
        p.blue  = 8'($urandom_range(0, 255));
        p.alpha = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                p.red = '0;
                p.green = '0;
                p.blue = '0;
            end
            3: begin
                p.red = 8'hFF;
                p.green = 8'hFF;
                p.blue = 8'hFF;
            end
            4: begin
                // Nearly black: only one channel is lit.
                case ($urandom_range(0, 2))
                    0: begin p.green = '0; p.blue = '0; end
                    1: begin p.red = '0; p.blue = '0; end
                    default: begin p.red = '0; p.green = '0; end
                endcase
            end
            default: ;
        endcase
        case ($urandom_range(0, 5))
            0: p.alpha = 8'h00;
            1: p.alpha = 8'hFF;
            2: p.alpha = cfg_thr - 8'd1;
            3: p.alpha = cfg_thr;
            default: ;
        endcase
        return p;
    endfunction

    // Queues whole rows of random pixels, mostly short with a few long ones.
    task automatic queue_rows(input int n_px);
        int left;
        int run;
        t_px_item item;
        left = n_px;
        while (left > 0) begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                              : $urandom_range(1, 24);
            if (run > left) begin
                run = left;
            end
            for (int i = 0; i < run; i++) begin
                item.px = rand_pixel();
                item.row_end = (i == run - 1);
                pixel_q.push_back(item);
                queued_cnt++;
            end
            left -= run;
        end
    endtask

    initial begin
        t_fmt fmt;
        logic [7:0] thr;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: RGB565 with threshold 128.
        push_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        push_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        push_pixel(8'hFF, 8'h00, 8'hFF, 8'h7F, 1'b0);
        push_pixel(8'h12, 8'h34, 8'h56, 8'h80, 1'b1);
        settle();

        // A zero threshold never keys, even at alpha zero.
        write_reg(REG_ALPHA_THRESHOLD, 8'h00);
        write_format(FMT_RGB332);
        push_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b0);
        push_pixel(8'hA5, 8'h5A, 8'hC3, 8'hFF, 1'b1);
        settle();
        write_reg(REG_ALPHA_THRESHOLD, 8'hFF);
        push_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFE, 1'b0);
        push_pixel(8'h00, 8'hFF, 8'h00, 8'hFF, 1'b1);
        settle();

        write_format(FMT_BGRA);
        push_pixel(8'h01, 8'h02, 8'h03, 8'h00, 1'b0);
        push_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        settle();

        // Mono: a full byte closed by a row end on its eighth pixel, then a
        // short row padded with zeros.
        write_format(FMT_MONO);
        push_pixel(8'h00, 8'h00, 8'h00, 8'hFF, 1'b0);
        push_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        push_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        push_pixel(8'h00, 8'h00, 8'h01, 8'hFF, 1'b0);
        push_pixel(8'h01, 8'h00, 8'h00, 8'hFF, 1'b0);
        push_pixel(8'h00, 8'h00, 8'h00, 8'hFF, 1'b0);
        push_pixel(8'h00, 8'h01, 8'h00, 8'hFF, 1'b0);
        push_pixel(8'h00, 8'h00, 8'h00, 8'hFF, 1'b1);
        push_pixel(8'h00, 8'h00, 8'h00, 8'hFF, 1'b0);
        push_pixel(8'h00, 8'h00, 8'h00, 8'hFF, 1'b1);
        // A partial byte survives writes to unmapped indexes.
        push_pixel(8'h00, 8'h00, 8'h00, 8'hFF, 1'b0);
        push_pixel(8'h80, 8'h00, 8'h00, 8'hFF, 1'b0);
        push_pixel(8'h00, 8'h00, 8'h00, 8'hFF, 1'b0);
        settle();
        write_reg(REG_SPARE_LO, 8'hFF);
        write_reg(REG_SPARE_HI, 8'h00);
        push_pixel(8'h00, 8'h00, 8'h00, 8'hFF, 1'b1);
        // A format write drops the partial byte, even to the same format.
        push_pixel(8'h00, 8'h00, 8'h00, 8'hFF, 1'b0);
        push_pixel(8'h00, 8'h00, 8'h00, 8'hFF, 1'b0);
        settle();
        write_format(FMT_MONO);
        push_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        settle();

        for (int ph = 0; ph < PHASES; ph++) begin
            fmt = t_fmt'(2'((ph + ph / 4) % 4));
            case ($urandom_range(0, 5))
                0: thr = 8'h00;
                1: thr = 8'h01;
                2: thr = 8'h80;
                3: thr = 8'hFE;
                4: thr = 8'hFF;
                default: thr = 8'($urandom_range(0, 255));
            endcase
            if ($urandom_range(0, 1) == 1) begin
                write_format(fmt);
                write_reg(REG_ALPHA_THRESHOLD, thr);
            end else begin
                write_reg(REG_ALPHA_THRESHOLD, thr);
                write_format(fmt);
            end
            case (ph % 4)
                0: begin src_idle_pct = 0; sink_stall_pct = 0; end
                1: begin src_idle_pct = 67; sink_stall_pct = 0; end
                2: begin src_idle_pct = 0; sink_stall_pct = 67; end
                default: begin src_idle_pct = 9; sink_stall_pct = 9; end
            endcase
            queue_rows(PHASE_PIXELS);
            settle();
        end

        if (err_cnt == 0 && awaited_words.size() == 0) begin
            $display("[rgba_pixel_format_converter] OK");
        end else begin
            $display("[rgba_pixel_format_converter] ERROR");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("[rgba_pixel_format_converter] ERROR");
        $finish;
    end

endmodule
